// ===== rtl/lqa_report_word_unpacker_unit_defines.svh =====
// Assertion macros for the LQA report unpacker checker file.
`ifndef LQA_REPORT_WORD_UNPACKER_UNIT_DEFINES_SVH
`define LQA_REPORT_WORD_UNPACKER_UNIT_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define LQA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds during reset.
`define LQA_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lqa_pkg.sv =====
// Shared constants and types for the LQA report word unpacker.
package lqa_pkg;

   localparam int unsigned WordBits   = 21;  // bits per data word
   localparam int unsigned ReportBits = 36;  // bits per packed report
   localparam int unsigned BufBits    = 56;  // bit buffer depth
   localparam int unsigned HeldBits   = 6;   // holds 0..56
   localparam int unsigned RestBits   = 5;   // leftover after a report, 0..20
   localparam int unsigned CountBits  = 8;   // report count in header
   localparam int unsigned DesigBits  = 20;  // frequency designator
   localparam int unsigned FreqBits   = 27;  // designator times step
   localparam int unsigned FreqStep   = 100; // hertz per designator unit

   localparam logic [FreqBits-1:0] FreqMax = FreqBits'(104857500);

   // Item opcodes
   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   typedef struct packed {
      logic                op;
      logic [WordBits-1:0] payload;
   } in_item_type;

   typedef struct packed {
      logic [FreqBits-1:0] freq_hz;
      logic [2:0]          age;
      logic [2:0]          multipath;
      logic [4:0]          sinad;
      logic [4:0]          ber;
      logic                last;
   } report_type;

endpackage

// ===== rtl/lqa_req_if.sv =====
// Input channel: header and data words.
interface lqa_req_if;
   import lqa_pkg::*;

   logic                valid;
   logic                ready;
   logic                op;
   logic [WordBits-1:0] payload;

   modport source (output valid, output op, output payload, input ready);
   modport sink   (input valid, input op, input payload, output ready);
endinterface

// ===== rtl/lqa_rsp_if.sv =====
// Result channel: one unpacked LQA report per item.
interface lqa_rsp_if;
   import lqa_pkg::*;

   logic                valid;
   logic                ready;
   logic [FreqBits-1:0] freq_hz;
   logic [2:0]          age;
   logic [2:0]          multipath;
   logic [4:0]          sinad;
   logic [4:0]          ber;
   logic                last;

   modport source (output valid, output freq_hz, output age, output multipath,
                   output sinad, output ber, output last, input ready);
   modport sink   (input valid, input freq_hz, input age, input multipath,
                   input sinad, input ber, input last, output ready);
endinterface

// ===== rtl/lqa_report_word_unpacker_unit.sv =====
// LQA report unpacker: takes a header word (report count in bits 7:0) and then
// 21-bit data words, and emits one 36-bit report (frequency in Hz, age,
// multipath, SINAD, BER, last flag) each time enough bits have arrived. One word
// is taken per clock cycle as long as the result side keeps up; a word waits in the
// input register, and its report is loaded into the result register when the word
// moves on. The result register lets the next word in while a report waits, and
// req.ready follows rsp.ready in the same cycle once both registers are full. No
// words are taken while reset is high.
module lqa_report_word_unpacker_unit (
   input  logic    clock,
   input  logic    reset,
   lqa_req_if.sink  req,
   lqa_rsp_if.source rsp
);
   import lqa_pkg::*;

   logic        room, fire, has_report;
   in_item_type item;
   report_type  report;

   lqa_in_stage u_in_stage (
      .clock (clock),
      .reset (reset),
      .room  (room),
      .req   (req),
      .fire  (fire),
      .item  (item)
   );

   lqa_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (item),
      .has_report (has_report),
      .report     (report)
   );

   lqa_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (has_report),
      .report (report),
      .room   (room),
      .rsp    (rsp)
   );
endmodule

// ===== rtl/lqa_in_stage.sv =====
// Input register: holds one accepted word until the core consumes it.
module lqa_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 room,
   lqa_req_if.sink              req,
   output logic                 fire,
   output lqa_pkg::in_item_type item
);
   import lqa_pkg::*;

   logic        valid_ff, valid_in;
   in_item_type item_ff;
   logic        take;

   // Held word moves on when the result side has room
   assign fire      = valid_ff && room;
   assign req.ready = !reset && (!valid_ff || fire);
   assign take      = req.valid && req.ready;
   assign valid_in  = take || (valid_ff && !fire);
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.op      <= req.op;
         item_ff.payload <= req.payload;
      end
   end
endmodule

// ===== rtl/lqa_unpack.sv =====
// Message state and bit buffer; slices a 36-bit report out when one is complete.
module lqa_unpack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  lqa_pkg::in_item_type item,
   output logic                 has_report,
   output lqa_pkg::report_type  report
);
   import lqa_pkg::*;

   logic                 active_ff, active_in;
   logic [CountBits-1:0] left_ff, left_in, left_dec;
   logic [BufBits-1:0]   bits_ff, bits_in, shifted, aligned;
   logic [HeldBits-1:0]  held_ff, held_in, held_sum, rest_full;
   logic [RestBits-1:0]  rest;
   logic [ReportBits-1:0] rep_word;
   logic [DesigBits-1:0] desig;
   logic                 full, is_last, is_data;

   // Append the new word, MSB first; bits above the held count are don't-care
   assign shifted   = {bits_ff[BufBits-WordBits-1:0], item.payload};
   assign held_sum  = held_ff + HeldBits'(WordBits);
   assign full      = held_sum >= HeldBits'(ReportBits);
   assign rest_full = held_sum - HeldBits'(ReportBits);
   assign rest      = rest_full[RestBits-1:0];
   assign aligned   = shifted >> rest;
   assign rep_word  = aligned[ReportBits-1:0];
   assign left_dec  = left_ff - CountBits'(1);
   assign is_last   = (left_dec == '0);
   assign is_data   = (item.op == OP_DATA);

   // Report fields, MSB to LSB: designator, age, multipath, SINAD, BER
   assign desig            = rep_word[ReportBits-1 -: DesigBits];
   assign report.freq_hz   = FreqBits'(desig) * FreqBits'(FreqStep);
   assign report.age       = rep_word[15:13];
   assign report.multipath = rep_word[12:10];
   assign report.sinad     = rep_word[9:5];
   assign report.ber       = rep_word[4:0];
   assign report.last      = is_last;

   assign has_report = fire && is_data && active_ff && full;

   // Next state
   always_comb begin
      active_in = active_ff;
      left_in   = left_ff;
      held_in   = held_ff;
      bits_in   = bits_ff;
      if (!is_data) begin
         // Header restarts the message
         left_in   = item.payload[CountBits-1:0];
         active_in = (item.payload[CountBits-1:0] != '0);
         held_in   = '0;
      end else if (active_ff) begin
         bits_in = shifted;
         if (full) begin
            left_in = left_dec;
            held_in = HeldBits'(rest);
            if (is_last) begin
               // Pad bits are dropped with the message
               active_in = 1'b0;
               held_in   = '0;
            end
         end else begin
            held_in = held_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         left_ff   <= '0;
         held_ff   <= '0;
      end else if (fire) begin
         active_ff <= active_in;
         left_ff   <= left_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         bits_ff <= bits_in;
      end
   end
endmodule

// ===== rtl/lqa_out_stage.sv =====
// Result register: holds a report until the sink takes it.
module lqa_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lqa_pkg::report_type report,
   output logic                room,
   lqa_rsp_if.source           rsp
);
   import lqa_pkg::*;

   logic       valid_ff, valid_in;
   report_type data_ff;

   // Free now, or emptied at this edge
   assign room     = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= report;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.freq_hz   = data_ff.freq_hz;
   assign rsp.age       = data_ff.age;
   assign rsp.multipath = data_ff.multipath;
   assign rsp.sinad     = data_ff.sinad;
   assign rsp.ber       = data_ff.ber;
   assign rsp.last      = data_ff.last;
endmodule

// ===== rtl/lqa_unpack_checker.sv =====
// Port-level checks for the LQA report unpacker, bound to the top level.
`include "lqa_report_word_unpacker_unit_defines.svh"

module lqa_unpack_checker (
   input logic       clock,
   input logic       reset,
   lqa_req_if.sink   req,
   lqa_rsp_if.source rsp
);
   import lqa_pkg::*;

   logic [$bits(report_type)-1:0] rsp_fields;
   logic                          stalled;

   // Offered report as one vector, and the stall condition
   assign rsp_fields = {rsp.freq_hz, rsp.age, rsp.multipath, rsp.sinad, rsp.ber, rsp.last};
   assign stalled    = rsp.valid && !rsp.ready;

   // No report is offered right after reset
   `LQA_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp.valid ##1 !rsp.valid, "early report")
   // Nothing is taken while reset is high
   `LQA_ASSERT_NR(a_no_take_in_reset, clock, reset |-> !req.ready, "word taken during reset")
   // Frequency stays within designator range times step
   `LQA_ASSERT(a_freq_range, clock, reset, rsp.valid |-> rsp.freq_hz <= FreqMax, "freq range")
   // A stalled report stays offered
   `LQA_ASSERT(a_rsp_hold, clock, reset, stalled |=> rsp.valid, "report dropped while stalled")
   // A stalled report keeps its fields
   `LQA_ASSERT(a_rsp_stable, clock, reset, stalled |=> $stable(rsp_fields), "report changed")
endmodule

bind lqa_report_word_unpacker_unit lqa_unpack_checker u_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);
